/* rtl/core/nnueacc_pkg.sv */
// Shared constants, types and helpers of the NNUE accumulator core.
package nnueacc_pkg;

    localparam int LANES    = 64;
    localparam int FEATURES = 768;
    localparam int HALF     = LANES / 2;

    localparam int LIDX_W   = $clog2(LANES);
    localparam int AADDR_W  = $clog2(2 * LANES);
    localparam int ADEPTH   = 2 * LANES;
    localparam int WDEPTH   = FEATURES * LANES;
    localparam int WADDR_W  = $clog2(WDEPTH);

    localparam int DATA_W   = 16;
    localparam int CLAMP_W  = 15;
    localparam int SHIFT_W  = 5;
    localparam int PROD_W   = 2 * CLAMP_W;
    localparam int ACT_W    = 8;
    localparam int POS_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [2:0] OP_WR_WEIGHT = 3'd0;
    localparam logic [2:0] OP_WR_ACC    = 3'd1;
    localparam logic [2:0] OP_ADD_ROW   = 3'd2;
    localparam logic [2:0] OP_SUB_ROW   = 3'd3;
    localparam logic [2:0] OP_ACTIVATE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = 2'd1;

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd255;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd9;

    typedef struct packed {
        logic [CLAMP_W-1:0] clamp_max;
        logic [SHIFT_W-1:0] product_shift;
    } t_cfg;

    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_act_tag;

    // accumulator entry of a perspective's lane
    function automatic logic [AADDR_W-1:0] acc_addr(input logic persp,
                                                    input logic [LIDX_W-1:0] lane);
        logic [AADDR_W-1:0] base;
        base = persp ? AADDR_W'(LANES) : '0;
        return base + AADDR_W'(lane);
    endfunction

    // clamp a signed 16-bit value to [0, cmax]
    function automatic logic [CLAMP_W-1:0] clip(input logic [DATA_W-1:0] v,
                                                input logic [CLAMP_W-1:0] cmax);
        logic [CLAMP_W-1:0] mag;
        mag = v[CLAMP_W-1:0];
        if (v[DATA_W-1]) begin
            return '0;
        end else if (mag > cmax) begin
            return cmax;
        end else begin
            return mag;
        end
    endfunction

endpackage

/* rtl/core/nnue_accumulator_pairwise_activation_core.sv */
// Top level: NNUE accumulator with row add/subtract and pairwise activation.
//
// Command channel: an item is taken at a clock edge with i_start high and
// o_busy low. Fields: operation, perspective, feature, lane, value.
//   write weight / write accumulator lane: done at the accepting edge, the
//     block is ready again the next cycle.
//   add / subtract row: one lane per cycle through the weight RAM and the
//     accumulator RAM (read, then add and write back the next cycle);
//     o_busy stays high through the last write-back.
//   activate: two accumulator lanes read per cycle from the dual-read
//     accumulator RAM, o_busy high until the last pair is read. Results come out
//     one per cycle on o_strobe, the first after the accumulator read, product
//     and output registers, position counting up, o_last on the final one.
// The result channel has no back-pressure: each result shows for one cycle.
// Config: i_cfg_valid with i_cfg_index (0 clamp_max, 1 product_shift) and
// i_cfg_data; o_cfg_ready is always high. Write only while idle.
// Reset (synchronous, i_rst_n low): accumulators read as zero, clamp_max
// 255, product_shift 9; the weight RAM keeps whatever it held.
module nnue_accumulator_pairwise_activation_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [2:0]                              i_operation,
    input  logic                                    i_perspective,
    input  logic [9:0]                              i_feature,
    input  logic [5:0]                              i_lane,
    input  logic signed [15:0]                      i_value,
    output logic                                    o_strobe,
    output logic [7:0]                              o_activation,
    output logic [4:0]                              o_position,
    output logic                                    o_last,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [nnueacc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nnueacc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROW  = 3'b010,
        S_ACT  = 3'b100
    } t_state;

    t_state                                 r_state, n_state;
    logic [nnueacc_pkg::LIDX_W-1:0]         r_cnt, n_cnt;
    logic                                   r_persp, n_persp;
    logic                                   r_sub, n_sub;
    logic [nnueacc_pkg::WADDR_W-1:0]        r_row_base, n_row_base;
    logic                                   r_wb_vld;
    logic [nnueacc_pkg::AADDR_W-1:0]        r_wb_addr;
    nnueacc_pkg::t_act_tag                  r_tag, n_tag;
    nnueacc_pkg::t_cfg                      r_cfg;

    logic                                   w_accept;
    logic                                   w_feat_ok;
    logic                                   w_lane_ok;
    logic [nnueacc_pkg::WADDR_W-1:0]        w_row_base_in;
    logic                                   w_wgt_we;
    logic                                   w_acc_wr;
    logic [nnueacc_pkg::DATA_W-1:0]         w_wgt_rdata;
    logic [nnueacc_pkg::DATA_W-1:0]         w_acc_rdata0;
    logic [nnueacc_pkg::DATA_W-1:0]         w_acc_rdata1;
    logic                                   w_acc_we;
    logic [nnueacc_pkg::AADDR_W-1:0]        w_acc_waddr;
    logic [nnueacc_pkg::DATA_W-1:0]         w_acc_wdata;
    logic [nnueacc_pkg::DATA_W-1:0]         w_row_sum;
    logic [nnueacc_pkg::AADDR_W-1:0]        w_raddr0;
    logic [nnueacc_pkg::AADDR_W-1:0]        w_raddr1;
    logic                                   w_cnt_end;

    // ---------------- command decode ----------------
    assign o_busy        = (r_state != S_IDLE) || r_wb_vld;
    assign w_accept      = i_start && !o_busy;
    assign w_feat_ok     = 32'(i_feature) < 32'(nnueacc_pkg::FEATURES);
    assign w_lane_ok     = 32'(i_lane) < 32'(nnueacc_pkg::LANES);
    assign w_row_base_in = nnueacc_pkg::WADDR_W'(i_feature)
                         * nnueacc_pkg::WADDR_W'(nnueacc_pkg::LANES);

    assign w_wgt_we = w_accept && (i_operation == nnueacc_pkg::OP_WR_WEIGHT)
                    && w_feat_ok && w_lane_ok;
    assign w_acc_wr = w_accept && (i_operation == nnueacc_pkg::OP_WR_ACC) && w_lane_ok;

    // ---------------- sequencer ----------------
    // both row and activate walk r_cnt over lanes; the row end is LANES-1,
    // the activate end is the last lane of the lower half
    assign w_cnt_end = (r_state == S_ROW)
                     ? (r_cnt == nnueacc_pkg::LIDX_W'(nnueacc_pkg::LANES - 1))
                     : (r_cnt == nnueacc_pkg::LIDX_W'(nnueacc_pkg::HALF - 1));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_persp    = r_persp;
        n_sub      = r_sub;
        n_row_base = r_row_base;
        n_tag.vld  = 1'b0;
        n_tag.pos  = nnueacc_pkg::POS_W'(r_cnt);
        n_tag.last = w_cnt_end;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt      = '0;
                    n_persp    = i_perspective;
                    n_sub      = (i_operation == nnueacc_pkg::OP_SUB_ROW);
                    n_row_base = w_row_base_in;
                    if (((i_operation == nnueacc_pkg::OP_ADD_ROW)
                         || (i_operation == nnueacc_pkg::OP_SUB_ROW)) && w_feat_ok) begin
                        n_state = S_ROW;
                    end else if (i_operation == nnueacc_pkg::OP_ACTIVATE) begin
                        n_state = S_ACT;
                    end
                end
            end
            S_ROW: begin
                n_cnt = r_cnt + 1'b1;
                if (w_cnt_end) begin
                    n_state = S_IDLE;
                end
            end
            S_ACT: begin
                n_tag.vld = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (w_cnt_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_wb_vld <= 1'b0;
            r_tag    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_wb_vld <= (r_state == S_ROW);
            r_tag    <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_persp    <= n_persp;
        r_sub      <= n_sub;
        r_row_base <= n_row_base;
        r_wb_addr  <= w_raddr0;
    end

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clamp_max     <= nnueacc_pkg::CLAMP_RESET;
            r_cfg.product_shift <= nnueacc_pkg::SHIFT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nnueacc_pkg::CFG_CLAMP_MAX: begin
                    r_cfg.clamp_max <= i_cfg_data[nnueacc_pkg::CLAMP_W-1:0];
                end
                nnueacc_pkg::CFG_SHIFT: begin
                    r_cfg.product_shift <= i_cfg_data[nnueacc_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- memories ----------------
    // read lane r_cnt (and its upper-half partner); row results are written
    // back the cycle after their read, so a read and the write never hit the same lane
    assign w_raddr0 = nnueacc_pkg::acc_addr(r_persp, r_cnt);
    assign w_raddr1 = nnueacc_pkg::acc_addr(r_persp,
                          r_cnt + nnueacc_pkg::LIDX_W'(nnueacc_pkg::HALF));

    assign w_row_sum   = r_sub ? (w_acc_rdata0 - w_wgt_rdata) : (w_acc_rdata0 + w_wgt_rdata);
    assign w_acc_we    = w_acc_wr || r_wb_vld;
    assign w_acc_waddr = r_wb_vld ? r_wb_addr
                       : nnueacc_pkg::acc_addr(i_perspective,
                                               nnueacc_pkg::LIDX_W'(i_lane));
    assign w_acc_wdata = r_wb_vld ? w_row_sum : i_value;

    nnueacc_wram u_wram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (w_row_base_in + nnueacc_pkg::WADDR_W'(i_lane)),
        .i_wdata (i_value),
        .i_raddr (r_row_base + nnueacc_pkg::WADDR_W'(r_cnt)),
        .o_rdata (w_wgt_rdata)
    );

    nnueacc_aram u_aram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_acc_we),
        .i_waddr  (w_acc_waddr),
        .i_wdata  (w_acc_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_acc_rdata0),
        .o_rdata1 (w_acc_rdata1)
    );

    nnueacc_act u_act (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_tag        (r_tag),
        .i_lo         (w_acc_rdata0),
        .i_hi         (w_acc_rdata1),
        .o_strobe     (o_strobe),
        .o_activation (o_activation),
        .o_position   (o_position),
        .o_last       (o_last)
    );

    // ---------------- checks ----------------
    a_one_acc_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc_wr && r_wb_vld))
        else $error("accumulator write collides with row write-back");

    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result directly after end of run");

    a_run_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=>
            (o_strobe && (o_position == 5'($past(o_position) + 5'd1))))
        else $error("activation run broken or out of order");

    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> !w_accept)
        else $error("item accepted during row update");

endmodule

/* rtl/core/nnueacc_wram.sv */
// Weight store: single-port-write, single-port-read synchronous RAM.
module nnueacc_wram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [nnueacc_pkg::WADDR_W-1:0]     i_waddr,
    input  logic [nnueacc_pkg::DATA_W-1:0]      i_wdata,
    input  logic [nnueacc_pkg::WADDR_W-1:0]     i_raddr,
    output logic [nnueacc_pkg::DATA_W-1:0]      o_rdata
);

    logic [nnueacc_pkg::DATA_W-1:0] r_mem [nnueacc_pkg::WDEPTH];
    logic [nnueacc_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/nnueacc_aram.sv */
// Accumulator store: one write port, two read ports, zero until written.
module nnueacc_aram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [nnueacc_pkg::AADDR_W-1:0]     i_waddr,
    input  logic [nnueacc_pkg::DATA_W-1:0]      i_wdata,
    input  logic [nnueacc_pkg::AADDR_W-1:0]     i_raddr0,
    input  logic [nnueacc_pkg::AADDR_W-1:0]     i_raddr1,
    output logic [nnueacc_pkg::DATA_W-1:0]      o_rdata0,
    output logic [nnueacc_pkg::DATA_W-1:0]      o_rdata1
);

    logic [nnueacc_pkg::DATA_W-1:0] r_mem [nnueacc_pkg::ADEPTH];
    logic [nnueacc_pkg::ADEPTH-1:0] r_vld;
    logic [nnueacc_pkg::DATA_W-1:0] r_rdata0;
    logic [nnueacc_pkg::DATA_W-1:0] r_rdata1;

    // valid bits stand in for the all-zero reset of the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_vld[i_raddr0] ? r_mem[i_raddr0] : '0;
        r_rdata1 <= r_vld[i_raddr1] ? r_mem[i_raddr1] : '0;
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

/* rtl/core/nnueacc_act.sv */
// Pairwise clipped-product activation: clamp and multiply, then shift and emit.
module nnueacc_act (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nnueacc_pkg::t_cfg                   i_cfg,
    input  nnueacc_pkg::t_act_tag               i_tag,
    input  logic [nnueacc_pkg::DATA_W-1:0]      i_lo,
    input  logic [nnueacc_pkg::DATA_W-1:0]      i_hi,
    output logic                                o_strobe,
    output logic [nnueacc_pkg::ACT_W-1:0]       o_activation,
    output logic [nnueacc_pkg::POS_W-1:0]       o_position,
    output logic                                o_last
);

    nnueacc_pkg::t_act_tag              r_tag;
    logic [nnueacc_pkg::PROD_W-1:0]     r_prod;
    logic [nnueacc_pkg::CLAMP_W-1:0]    w_c0;
    logic [nnueacc_pkg::CLAMP_W-1:0]    w_c1;
    logic [nnueacc_pkg::PROD_W-1:0]     w_shifted;
    logic                               r_strobe;
    logic [nnueacc_pkg::ACT_W-1:0]      r_activation;
    logic [nnueacc_pkg::POS_W-1:0]      r_position;
    logic                               r_last;

    assign w_c0      = nnueacc_pkg::clip(i_lo, i_cfg.clamp_max);
    assign w_c1      = nnueacc_pkg::clip(i_hi, i_cfg.clamp_max);
    assign w_shifted = r_prod >> i_cfg.product_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_tag    <= i_tag;
            r_strobe <= r_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= nnueacc_pkg::PROD_W'(w_c0) * nnueacc_pkg::PROD_W'(w_c1);
        r_activation <= w_shifted[nnueacc_pkg::ACT_W-1:0];
        r_position   <= r_tag.pos;
        r_last       <= r_tag.last;
    end

    assign o_strobe     = r_strobe;
    assign o_activation = r_activation;
    assign o_position   = r_position;
    assign o_last       = r_last & r_strobe;

endmodule

/* sim/nnueacc_result_check.sv */
// Result checker: tracks accumulator, weight and register state, predicts activation bytes.
module nnueacc_result_check
    import nnueacc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [2:0]            i_operation,
    input  logic                  i_perspective,
    input  logic [9:0]            i_feature,
    input  logic [5:0]            i_lane,
    input  logic [15:0]           i_value,
    input  logic                  i_strobe,
    input  logic [ACT_W-1:0]      i_activation,
    input  logic [POS_W-1:0]      i_position,
    input  logic                  i_last,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_pending
);

    typedef struct packed {
        logic [ACT_W-1:0] activation;
        logic [POS_W-1:0] position;
        logic             last;
    } act_byte_t;

    act_byte_t          expected_bytes [$];
    act_byte_t          want;
    logic [DATA_W-1:0]  acc_lanes [ADEPTH];
    logic [DATA_W-1:0]  weight_rows [WDEPTH];
    logic [CLAMP_W-1:0] clamp_max;
    logic [SHIFT_W-1:0] product_shift;

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    // signed lane value limited to [0, clamp_max]
    function automatic logic [CLAMP_W-1:0] clipped(input logic [DATA_W-1:0] v);
        if (v[DATA_W-1]) return '0;
        if (v > {1'b0, clamp_max}) return clamp_max;
        return v[CLAMP_W-1:0];
    endfunction

    function automatic act_byte_t pair_activation(input int base, input int k);
        logic [PROD_W-1:0] product;
        act_byte_t         r;
        product = PROD_W'(clipped(acc_lanes[base + k])) *
                  PROD_W'(clipped(acc_lanes[base + k + HALF]));
        product = product >> product_shift;
        r.activation = product[ACT_W-1:0];
        r.position   = POS_W'(k);
        r.last       = (k == HALF - 1);
        return r;
    endfunction

    task automatic apply_item();
        int                base;
        int                row;
        logic [DATA_W-1:0] w;
        base = i_perspective ? LANES : 0;
        row  = int'(i_feature) * LANES;
        case (i_operation)
            OP_WR_WEIGHT: begin
                if (i_feature < FEATURES && i_lane < LANES) weight_rows[row + i_lane] = i_value;
            end
            OP_WR_ACC: begin
                if (i_lane < LANES) acc_lanes[base + i_lane] = i_value;
            end
            OP_ADD_ROW, OP_SUB_ROW: begin
                if (i_feature < FEATURES) begin
                    for (int k = 0; k < LANES; k++) begin
                        w = weight_rows[row + k];
                        if (i_operation == OP_ADD_ROW) acc_lanes[base + k] = acc_lanes[base + k] + w;
                        else acc_lanes[base + k] = acc_lanes[base + k] - w;
                    end
                end
            end
            OP_ACTIVATE: begin
                for (int k = 0; k < HALF; k++) expected_bytes.push_back(pair_activation(base, k));
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ADEPTH; k++) acc_lanes[k] = '0;
            clamp_max     = CLAMP_RESET;
            product_shift = SHIFT_RESET;
            expected_bytes.delete();
        end else begin
            // results first: none can belong to an item taken at this edge
            if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    $error("result with no activation pending: activation %0d position %0d",
                           i_activation, i_position);
                    o_failures++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_activation !== want.activation) begin
                        $error("activation mismatch: expected %0d, got %0d",
                               want.activation, i_activation);
                        o_failures++;
                    end
                    if (i_position !== want.position) begin
                        $error("position mismatch: expected %0d, got %0d",
                               want.position, i_position);
                        o_failures++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d, got %0d", want.last, i_last);
                        o_failures++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLAMP_MAX: clamp_max     = i_cfg_data[CLAMP_W-1:0];
                    CFG_SHIFT:     product_shift = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) apply_item();
        end
        o_pending = expected_bytes.size();
    end

endmodule

/* sim/tb_nnue_accumulator_pairwise_activation_core.sv */
// Testbench top: stimulus, idling and verdict for the NNUE accumulator core.
module tb_nnue_accumulator_pairwise_activation_core;
    import nnueacc_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;       // results can trail the fall of busy
    localparam int CYCLE_LIMIT   = 400000;  // several times the slowest legal run
    localparam int ITEM_TARGET   = 370;
    localparam int FEATURE_FIELD_MAX = 1023;
    localparam int MAX_EXTRA_FILLS   = 3;

    // operation codes the block ignores
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [2:0]            i_operation = '0;
    logic                  i_perspective = 1'b0;
    logic [9:0]            i_feature = '0;
    logic [5:0]            i_lane = '0;
    logic signed [15:0]    i_value = '0;
    logic                  o_strobe;
    logic [7:0]            o_activation;
    logic [4:0]            o_position;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int failures;
    int bytes_pending;

    // run bookkeeping
    int cycle_count = 0;
    int idle_pct = 0;
    int useful_items = 0;
    int activate_items = 0;
    int register_settings = 1;
    int extra_fills = 0;
    bit row_loaded [FEATURES];
    int loaded_rows [$];

    nnue_accumulator_pairwise_activation_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_operation   (i_operation),
        .i_perspective (i_perspective),
        .i_feature     (i_feature),
        .i_lane        (i_lane),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_activation  (o_activation),
        .o_position    (o_position),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    nnueacc_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_operation   (i_operation),
        .i_perspective (i_perspective),
        .i_feature     (i_feature),
        .i_lane        (i_lane),
        .i_value       (i_value),
        .i_strobe      (o_strobe),
        .i_activation  (o_activation),
        .i_position    (o_position),
        .i_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_pending     (bytes_pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // weight values lean on the int16 extremes so row math wraps often
    function automatic logic [15:0] weight_word();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one item and hold it until taken. start stays high into the
    // next item unless the sender decides to idle for a while.
    task automatic send_item(input logic [2:0] op, input logic persp, input int feature,
                             input int lane, input logic [15:0] value);
        i_start       <= 1'b1;
        i_operation   <= op;
        i_perspective <= persp;
        i_feature     <= 10'(feature);
        i_lane        <= 6'(lane);
        i_value       <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (op == OP_ACTIVATE) activate_items++;
        // ignored items do not count toward the item budget
        if (!(op > OP_ACTIVATE ||
              (op != OP_WR_ACC && op != OP_ACTIVATE && feature >= FEATURES)))
            useful_items++;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            // mostly short gaps, now and then one longer than a row update
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 70)) @(posedge i_clk);
            else repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until the block has nothing left in flight. Row
    // updates give no results, so busy is watched too, then a short settle.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_activation_regs(input int clamp, input int shift);
        write_reg(CFG_CLAMP_MAX, clamp);
        write_reg(CFG_SHIFT, shift);
        register_settings++;
    endtask

    // Write a whole weight row in shuffled lane order. Only complete rows are
    // ever added or subtracted, so no unwritten weight is read.
    task automatic fill_row(input int feature, input bit extremes);
        int order [LANES];
        int j;
        int k;
        int tmp;
        for (j = 0; j < LANES; j++) order[j] = j;
        for (j = LANES - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        for (j = 0; j < LANES; j++) begin
            send_item(OP_WR_WEIGHT, $urandom_range(0, 1), feature, order[j],
                      extremes ? (order[j][0] ? 16'h8000 : 16'h7FFF) : weight_word());
        end
        if (!row_loaded[feature]) loaded_rows.push_back(feature);
        row_loaded[feature] = 1'b1;
    endtask

    function automatic int any_loaded_row();
        return loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
    endfunction

    // One random item; most are well formed, the rest are ignored noise.
    task automatic random_item();
        int   r;
        int   f;
        logic p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 1);
        if (r < 30) begin
            send_item((r < 16) ? OP_ADD_ROW : OP_SUB_ROW, p, any_loaded_row(),
                      $urandom_range(0, LANES - 1), 16'($urandom));
        end else if (r < 50) begin
            send_item(OP_ACTIVATE, p, $urandom_range(0, FEATURE_FIELD_MAX),
                      $urandom_range(0, LANES - 1), 16'($urandom));
        end else if (r < 65) begin
            send_item(OP_WR_ACC, p, $urandom_range(0, FEATURE_FIELD_MAX),
                      $urandom_range(0, LANES - 1), weight_word());
        end else if (r < 73) begin
            // loaded rows stay loaded; partial writes to other rows are harmless
            f = ($urandom_range(0, 1) == 0) ? any_loaded_row()
                                            : $urandom_range(0, FEATURE_FIELD_MAX);
            send_item(OP_WR_WEIGHT, p, f, $urandom_range(0, LANES - 1), weight_word());
        end else if (r < 78) begin
            send_item(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), p,
                      $urandom_range(0, FEATURE_FIELD_MAX), $urandom_range(0, LANES - 1),
                      16'($urandom));
        end else if (r < 82) begin
            // row update past the last feature: ignored
            send_item((r < 80) ? OP_ADD_ROW : OP_SUB_ROW, p,
                      $urandom_range(FEATURES, FEATURE_FIELD_MAX),
                      $urandom_range(0, LANES - 1), 16'($urandom));
        end else if (r < 84 && extra_fills < MAX_EXTRA_FILLS) begin
            do f = $urandom_range(0, FEATURES - 1); while (row_loaded[f]);
            extra_fills++;
            fill_row(f, 1'b0);
        end else begin
            send_item(OP_ACTIVATE, p, $urandom_range(0, FEATURE_FIELD_MAX),
                      $urandom_range(0, LANES - 1), 16'($urandom));
        end
    endtask

    initial begin
        int phase_goal;
        int random_base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Row 0 holds only int16 extremes (wraps on the second add), the last
        // row holds mixed values. Both are complete before any row update.
        fill_row(0, 1'b1);
        fill_row(FEATURES - 1, 1'b0);

        // Directed part under the reset register values first.
        idle_pct = 25;
        send_item(OP_WR_ACC, 1'b0, 0, 0, 16'h7FFF);
        send_item(OP_WR_ACC, 1'b0, 0, HALF, 16'h7FFF);
        send_item(OP_WR_ACC, 1'b0, 0, 1, 16'h8000);
        send_item(OP_WR_ACC, 1'b0, 0, HALF + 1, 16'd300);
        send_item(OP_WR_ACC, 1'b0, 0, HALF - 1, 16'd123);
        send_item(OP_WR_ACC, 1'b0, 0, LANES - 1, 16'hFFFF);
        send_item(OP_ACTIVATE, 1'b0, 0, 0, 16'h0000);
        send_item(OP_ADD_ROW, 1'b1, 0, 0, 16'h0000);
        send_item(OP_ADD_ROW, 1'b1, 0, 0, 16'h0000);
        send_item(OP_SUB_ROW, 1'b1, FEATURES - 1, LANES - 1, 16'hFFFF);
        // row updates past the last feature are dropped
        send_item(OP_ADD_ROW, 1'b0, FEATURE_FIELD_MAX, 0, 16'h0000);
        send_item(OP_SUB_ROW, 1'b0, FEATURES, 0, 16'h0000);
        send_item(OP_WR_WEIGHT, 1'b1, FEATURES - 1, LANES - 1, 16'h8000);
        send_item(OP_WR_WEIGHT, 1'b0, FEATURE_FIELD_MAX, 0, 16'h7FFF);
        for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++)
            send_item(3'(op), 1'b1, 0, LANES - 1, 16'hFFFF);
        send_item(OP_ACTIVATE, 1'b1, FEATURE_FIELD_MAX, LANES - 1, 16'hFFFF);
        // zero clamp bound: every byte must read zero
        write_reg(CFG_CLAMP_MAX, 0);
        register_settings++;
        send_item(OP_ACTIVATE, 1'b1, 0, 0, 16'h0000);
        // widest clamp, no shift: only the low byte of the product survives
        set_activation_regs(32767, 0);
        send_item(OP_ACTIVATE, 1'b0, 0, 0, 16'h0000);
        send_item(OP_ACTIVATE, 1'b1, 0, 0, 16'h0000);
        // narrowest nonzero clamp, full shift
        set_activation_regs(1, 31);
        send_item(OP_ACTIVATE, 1'b1, 0, 0, 16'h0000);

        // Random part in three idling phases, registers changed between them.
        random_base = useful_items;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 35;
                    set_activation_regs($urandom_range(64, 512), $urandom_range(4, 12));
                end
                1: begin
                    idle_pct = 66;
                    set_activation_regs($urandom_range(4096, 32767), $urandom_range(18, 26));
                end
                default: begin
                    idle_pct = 0;
                    set_activation_regs($urandom_range(1, 32767), $urandom_range(0, 31));
                end
            endcase
            phase_goal = random_base + (ITEM_TARGET - random_base) * (phase + 1) / 3;
            while (useful_items < phase_goal) random_item();
        end

        drain();
        $display("Covered %0d items (%0d activate) over %0d register settings,",
                 useful_items, activate_items, register_settings);
        $display("with %0d weight rows loaded and idling at 35, 66 and 0 percent.",
                 loaded_rows.size());
        if (failures == 0 && bytes_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/nnueacc_pkg.sv
rtl/core/nnueacc_wram.sv
rtl/core/nnueacc_aram.sv
rtl/core/nnueacc_act.sv
rtl/core/nnue_accumulator_pairwise_activation_core.sv
sim/nnueacc_result_check.sv
sim/tb_nnue_accumulator_pairwise_activation_core.sv
